/* hw/rtl/psd_pkg.sv */
package psd_pkg;

    typedef enum logic [1:0] {
        REGION_ZERO     = 2'd0,
        REGION_START    = 2'd1,
        REGION_END      = 2'd2,
        REGION_INTERIOR = 2'd3
    } region_t;

    localparam int PREP_STAGES   = 5;
    localparam int FINISH_STAGES = 3;

endpackage

/* hw/rtl/psd_req_if.sv */
interface psd_req_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] seg_start_x;
    logic signed [COORD_BITS-1:0] seg_start_y;
    logic signed [COORD_BITS-1:0] seg_end_x;
    logic signed [COORD_BITS-1:0] seg_end_y;

    modport source (
        output valid, point_x, point_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
        output ready
    );
endinterface

/* hw/rtl/psd_rsp_if.sv */
interface psd_rsp_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic [2*COORD_BITS:0]        dist_sq;
    logic signed [COORD_BITS-1:0] foot_x;
    logic signed [COORD_BITS-1:0] foot_y;
    logic [1:0]                   region;

    modport source (
        output valid, dist_sq, foot_x, foot_y, region,
        input  ready
    );
    modport sink (
        input  valid, dist_sq, foot_x, foot_y, region,
        output ready
    );
endinterface

/* hw/rtl/point_segment_distance.sv */
// point_segment_distance
//
// req (sink): query point and segment end points, one transfer per item.
// rsp (source): squared distance, rounded foot point and region code,
// exactly one transfer per request, in request order.
//
// From request transfer to rsp.valid an item passes five setup stages
// (differences, products, length and dot product, region decision,
// division numerators), a chain of COORD_BITS + 2 divider cells that
// each settle one quotient bit for x and y, and three stages that select
// the foot and form the squared distance.
// Throughput is one item per cycle while rsp is not stalled.
//
// Every stage holds its item while the next one is full and stalled, so
// bubbles close up; when rsp is stalled and the whole chain is full,
// req.ready drops. Reset clears all valid flags; nothing else needs
// clearing and requests are taken in the first cycle after reset.
module point_segment_distance
    import psd_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    psd_req_if.sink                  req,
    psd_rsp_if.source                rsp
);
    localparam int N = COORD_BITS;
    localparam int W = 3 * N + 5;
    localparam int K = N + 2;
    localparam int S = PREP_STAGES + K + FINISH_STAGES;

    logic [S-1:0] valid_reg;
    logic [S-1:0] ready;

    logic [6*N-1:0]   crd;
    region_t          region_p;
    logic [2*N+1:0]   den_p;
    logic [W-1:0]     num_x, num_y;

    logic [6*N+1:0]   ctx   [K+1];
    logic [2*N+1:0]   den   [K+1];
    logic [W-1:0]     rem_x [K+1];
    logic [W-1:0]     rem_y [K+1];
    logic [K-1:0]     q_x   [K+1];
    logic [K-1:0]     q_y   [K+1];

    region_t          region_f;

    always_comb
    begin
        ready[S-1] = !valid_reg[S-1] || rsp.ready;
        for (int i = S - 2; i >= 0; i--)
            ready[i] = !valid_reg[i] || ready[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (ready[0])
                valid_reg[0] <= req.valid;
            for (int i = 1; i < S; i++)
                if (ready[i])
                    valid_reg[i] <= valid_reg[i-1];
        end
    end

    assign req.ready = ready[0];
    assign rsp.valid = valid_reg[S-1];

    psd_prep #(.N(N), .W(W)) u_prep (
        .clk         (clk),
        .load        (ready[PREP_STAGES-1:0]),
        .point_x     (req.point_x),
        .point_y     (req.point_y),
        .seg_start_x (req.seg_start_x),
        .seg_start_y (req.seg_start_y),
        .seg_end_x   (req.seg_end_x),
        .seg_end_y   (req.seg_end_y),
        .crd         (crd),
        .region      (region_p),
        .den         (den_p),
        .num_x       (num_x),
        .num_y       (num_y)
    );

    assign ctx[0]   = {crd, region_p};
    assign den[0]   = den_p;
    assign rem_x[0] = num_x;
    assign rem_y[0] = num_y;
    assign q_x[0]   = '0;
    assign q_y[0]   = '0;

    for (genvar j = 0; j < K; j++)
    begin : g_cell
        psd_div_cell #(.N(N), .W(W), .K(K), .BIT(K - 1 - j)) u_cell (
            .clk       (clk),
            .load      (ready[PREP_STAGES + j]),
            .ctx_in    (ctx[j]),
            .den_in    (den[j]),
            .rem_x_in  (rem_x[j]),
            .rem_y_in  (rem_y[j]),
            .q_x_in    (q_x[j]),
            .q_y_in    (q_y[j]),
            .ctx_out   (ctx[j+1]),
            .den_out   (den[j+1]),
            .rem_x_out (rem_x[j+1]),
            .rem_y_out (rem_y[j+1]),
            .q_x_out   (q_x[j+1]),
            .q_y_out   (q_y[j+1])
        );
    end

    psd_finish #(.N(N), .K(K)) u_finish (
        .clk     (clk),
        .load    (ready[S-1:PREP_STAGES+K]),
        .ctx     (ctx[K]),
        .q_x     (q_x[K]),
        .q_y     (q_y[K]),
        .dist_sq (rsp.dist_sq),
        .foot_x  (rsp.foot_x),
        .foot_y  (rsp.foot_y),
        .region  (region_f)
    );

    assign rsp.region = region_f;
endmodule

/* hw/rtl/psd_prep.sv */
module psd_prep
    import psd_pkg::*;
#(
    parameter int N = 16,
    parameter int W = 3 * N + 5
) (
    input  logic                       clk,
    input  logic [PREP_STAGES-1:0]     load,
    input  logic signed [N-1:0]        point_x,
    input  logic signed [N-1:0]        point_y,
    input  logic signed [N-1:0]        seg_start_x,
    input  logic signed [N-1:0]        seg_start_y,
    input  logic signed [N-1:0]        seg_end_x,
    input  logic signed [N-1:0]        seg_end_y,
    output logic [6*N-1:0]             crd,
    output region_t                    region,
    output logic [2*N+1:0]             den,
    output logic [W-1:0]               num_x,
    output logic [W-1:0]               num_y
);
    localparam int SW = W + 1;

    // coordinates ride along: {px, py, sx, sy, ex, ey}
    logic [6*N-1:0] crd1_reg, crd2_reg, crd3_reg, crd4_reg, crd5_reg;

    logic signed [N:0]     dx1_reg, dy1_reg, ux1_reg, uy1_reg;
    logic signed [N:0]     dx2_reg, dy2_reg, dx3_reg, dy3_reg;
    logic signed [2*N+1:0] dxx_reg, dyy_reg, tx_reg, ty_reg;
    logic [2*N:0]          l23_reg, l24_reg;
    logic signed [2*N+2:0] t3_reg;
    region_t               region4_reg, region5_reg;
    logic signed [2*N+2:0] plx_reg, ply_reg;
    logic signed [2*N+1:0] phx_reg, phy_reg;
    logic [2*N+1:0]        den_reg;
    logic [W-1:0]          nx_reg, ny_reg;

    region_t               region4_next;
    logic [2*N:0]          t_trunc;
    logic signed [SW-1:0]  nx_next, ny_next;

    always_comb
    begin
        if (l23_reg == '0)
            region4_next = REGION_ZERO;
        else if (t3_reg < 0)
            region4_next = REGION_START;
        else if (t3_reg > $signed({2'b00, l23_reg}))
            region4_next = REGION_END;
        else
            region4_next = REGION_INTERIOR;
    end

    assign t_trunc = t3_reg[2*N:0];

    // numerator 2*t*d + l2, offset by l2 << (N+2) to stay nonnegative
    always_comb
    begin
        nx_next = (SW'(phx_reg) <<< (N + 2)) + (SW'(plx_reg) <<< 1)
                + $signed(SW'(l24_reg)) + $signed(SW'(l24_reg) << (N + 2));
        ny_next = (SW'(phy_reg) <<< (N + 2)) + (SW'(ply_reg) <<< 1)
                + $signed(SW'(l24_reg)) + $signed(SW'(l24_reg) << (N + 2));
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            crd1_reg <= {point_x, point_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y};
            dx1_reg  <= {seg_end_x[N-1], seg_end_x} - {seg_start_x[N-1], seg_start_x};
            dy1_reg  <= {seg_end_y[N-1], seg_end_y} - {seg_start_y[N-1], seg_start_y};
            ux1_reg  <= {point_x[N-1], point_x} - {seg_start_x[N-1], seg_start_x};
            uy1_reg  <= {point_y[N-1], point_y} - {seg_start_y[N-1], seg_start_y};
        end
        if (load[1])
        begin
            crd2_reg <= crd1_reg;
            dx2_reg  <= dx1_reg;
            dy2_reg  <= dy1_reg;
            dxx_reg  <= dx1_reg * dx1_reg;
            dyy_reg  <= dy1_reg * dy1_reg;
            tx_reg   <= ux1_reg * dx1_reg;
            ty_reg   <= uy1_reg * dy1_reg;
        end
        if (load[2])
        begin
            crd3_reg <= crd2_reg;
            dx3_reg  <= dx2_reg;
            dy3_reg  <= dy2_reg;
            l23_reg  <= (2*N+1)'(dxx_reg + dyy_reg);
            t3_reg   <= (2*N+3)'(tx_reg) + (2*N+3)'(ty_reg);
        end
        if (load[3])
        begin
            crd4_reg    <= crd3_reg;
            l24_reg     <= l23_reg;
            region4_reg <= region4_next;
            plx_reg     <= $signed({1'b0, t_trunc[N:0]}) * dx3_reg;
            ply_reg     <= $signed({1'b0, t_trunc[N:0]}) * dy3_reg;
            phx_reg     <= $signed({1'b0, t_trunc[2*N:N+1]}) * dx3_reg;
            phy_reg     <= $signed({1'b0, t_trunc[2*N:N+1]}) * dy3_reg;
        end
        if (load[4])
        begin
            crd5_reg    <= crd4_reg;
            region5_reg <= region4_reg;
            den_reg     <= {l24_reg, 1'b0};
            nx_reg      <= W'(nx_next);
            ny_reg      <= W'(ny_next);
        end
    end

    assign crd    = crd5_reg;
    assign region = region5_reg;
    assign den    = den_reg;
    assign num_x  = nx_reg;
    assign num_y  = ny_reg;
endmodule

/* hw/rtl/psd_div_cell.sv */
module psd_div_cell #(
    parameter int N   = 16,
    parameter int W   = 3 * N + 5,
    parameter int K   = N + 2,
    parameter int BIT = 0
) (
    input  logic             clk,
    input  logic             load,
    input  logic [6*N+1:0]   ctx_in,
    input  logic [2*N+1:0]   den_in,
    input  logic [W-1:0]     rem_x_in,
    input  logic [W-1:0]     rem_y_in,
    input  logic [K-1:0]     q_x_in,
    input  logic [K-1:0]     q_y_in,
    output logic [6*N+1:0]   ctx_out,
    output logic [2*N+1:0]   den_out,
    output logic [W-1:0]     rem_x_out,
    output logic [W-1:0]     rem_y_out,
    output logic [K-1:0]     q_x_out,
    output logic [K-1:0]     q_y_out
);
    logic [6*N+1:0] ctx_reg;
    logic [2*N+1:0] den_reg;
    logic [W-1:0]   rx_reg, ry_reg;
    logic [K-1:0]   qx_reg, qy_reg;
    logic [W-1:0]   dsh;
    logic           fit_x, fit_y;

    // one restoring quotient bit per lane
    assign dsh   = W'(den_in) << BIT;
    assign fit_x = rem_x_in >= dsh;
    assign fit_y = rem_y_in >= dsh;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctx_reg <= ctx_in;
            den_reg <= den_in;
            rx_reg  <= fit_x ? rem_x_in - dsh : rem_x_in;
            ry_reg  <= fit_y ? rem_y_in - dsh : rem_y_in;
            qx_reg  <= {q_x_in[K-2:0], fit_x};
            qy_reg  <= {q_y_in[K-2:0], fit_y};
        end
    end

    assign ctx_out   = ctx_reg;
    assign den_out   = den_reg;
    assign rem_x_out = rx_reg;
    assign rem_y_out = ry_reg;
    assign q_x_out   = qx_reg;
    assign q_y_out   = qy_reg;
endmodule

/* hw/rtl/psd_finish.sv */
module psd_finish
    import psd_pkg::*;
#(
    parameter int N = 16,
    parameter int K = N + 2
) (
    input  logic                     clk,
    input  logic [FINISH_STAGES-1:0] load,
    input  logic [6*N+1:0]           ctx,
    input  logic [K-1:0]             q_x,
    input  logic [K-1:0]             q_y,
    output logic [2*N:0]             dist_sq,
    output logic signed [N-1:0]      foot_x,
    output logic signed [N-1:0]      foot_y,
    output region_t                  region
);
    logic [N-1:0] px, py, sx, sy, ex, ey;
    region_t      rin;

    logic [N-1:0]          px1_reg, py1_reg, fx1_reg, fy1_reg, fx2_reg, fy2_reg;
    logic [N-1:0]          fx3_reg, fy3_reg;
    region_t               r1_reg, r2_reg, r3_reg;
    logic signed [2*N+1:0] sqx_reg, sqy_reg;
    logic [2*N:0]          dist_reg;
    logic [N-1:0]          fx_next, fy_next;
    logic signed [N:0]     ax, ay;

    assign {px, py, sx, sy, ex, ey} = ctx[6*N+1:2];
    assign rin = region_t'(ctx[1:0]);

    // quotient carries an offset of 2^(N+1); the low N bits are unaffected
    always_comb
    begin
        case (rin)
            REGION_END:
            begin
                fx_next = ex;
                fy_next = ey;
            end
            REGION_INTERIOR:
            begin
                fx_next = sx + q_x[N-1:0];
                fy_next = sy + q_y[N-1:0];
            end
            default:
            begin
                fx_next = sx;
                fy_next = sy;
            end
        endcase
    end

    assign ax = {px1_reg[N-1], px1_reg} - {fx1_reg[N-1], fx1_reg};
    assign ay = {py1_reg[N-1], py1_reg} - {fy1_reg[N-1], fy1_reg};

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            px1_reg <= px;
            py1_reg <= py;
            fx1_reg <= fx_next;
            fy1_reg <= fy_next;
            r1_reg  <= rin;
        end
        if (load[1])
        begin
            sqx_reg <= ax * ax;
            sqy_reg <= ay * ay;
            fx2_reg <= fx1_reg;
            fy2_reg <= fy1_reg;
            r2_reg  <= r1_reg;
        end
        if (load[2])
        begin
            dist_reg <= (2*N+1)'(sqx_reg + sqy_reg);
            fx3_reg  <= fx2_reg;
            fy3_reg  <= fy2_reg;
            r3_reg   <= r2_reg;
        end
    end

    assign dist_sq = dist_reg;
    assign foot_x  = fx3_reg;
    assign foot_y  = fy3_reg;
    assign region  = r3_reg;
endmodule

/* verif/tb_point_segment_distance.sv */
module tb_point_segment_distance;
    import psd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS = 16;
    localparam int MAX_CYCLES = 400000;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t px;
        coord_t py;
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
    } query_t;

    typedef struct packed {
        logic [2*COORD_BITS:0] dist_sq;
        coord_t                foot_x;
        coord_t                foot_y;
        region_t               region;
    } nearest_t;

    logic clk;
    logic rst_n;

    psd_req_if #(.COORD_BITS(COORD_BITS)) req ();
    psd_rsp_if #(.COORD_BITS(COORD_BITS)) rsp ();

    point_segment_distance #(.COORD_BITS(COORD_BITS)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    query_t   query_q[$];
    nearest_t nearest_q[$];
    int       send_idle_pct;
    int       recv_idle_pct;
    int       mismatches = 0;
    int       rsp_count = 0;
    int       region_hits[4] = '{default: 0};
    int       cycles = 0;

    function automatic longint floor_quot(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic nearest_t nearest_point(query_t q);
        nearest_t r;
        longint   px, py, sx, sy, ex, ey, dx, dy, l2, dot, fx, fy;
        px = q.px; py = q.py; sx = q.sx; sy = q.sy; ex = q.ex; ey = q.ey;
        dx = ex - sx;
        dy = ey - sy;
        l2 = dx * dx + dy * dy;
        dot = (px - sx) * dx + (py - sy) * dy;
        if (l2 == 0)
        begin
            fx = sx; fy = sy; r.region = REGION_ZERO;
        end
        else if (dot < 0)
        begin
            fx = sx; fy = sy; r.region = REGION_START;
        end
        else if (dot > l2)
        begin
            fx = ex; fy = ey; r.region = REGION_END;
        end
        else
        begin
            fx = sx + floor_quot(2 * dot * dx + l2, 2 * l2);
            fy = sy + floor_quot(2 * dot * dy + l2, 2 * l2);
            r.region = REGION_INTERIOR;
        end
        r.foot_x  = fx[COORD_BITS-1:0];
        r.foot_y  = fy[COORD_BITS-1:0];
        r.dist_sq = (2*COORD_BITS+1)'((px - fx) * (px - fx) + (py - fy) * (py - fy));
        return r;
    endfunction

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            1: return coord_t'(int'($urandom_range(0, 40)) - 20);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic query_t rand_query();
        query_t q;
        q.px = rand_coord(); q.py = rand_coord();
        q.sx = rand_coord(); q.sy = rand_coord();
        case ($urandom_range(0, 9))
            0:
            begin
                q.ex = q.sx; q.ey = q.sy;
            end
            1:
            begin
                q.ex = coord_t'(int'(q.sx) + int'($urandom_range(0, 6)) - 3);
                q.ey = coord_t'(int'(q.sy) + int'($urandom_range(0, 6)) - 3);
            end
            default:
            begin
                q.ex = rand_coord(); q.ey = rand_coord();
            end
        endcase
        // put the point on the perpendicular through the start or end point for exact t = 0 or t = l2
        if ($urandom_range(0, 9) == 0)
        begin
            q.px = q.sx - (q.ey - q.sy);
            q.py = q.sy + (q.ex - q.sx);
            if ($urandom_range(0, 1))
            begin
                q.px = q.ex - (q.ey - q.sy);
                q.py = q.ey + (q.ex - q.sx);
            end
        end
        return q;
    endfunction

    function automatic query_t mk(int px, int py, int sx, int sy, int ex, int ey);
        query_t q;
        q.px = coord_t'(px); q.py = coord_t'(py);
        q.sx = coord_t'(sx); q.sy = coord_t'(sy);
        q.ex = coord_t'(ex); q.ey = coord_t'(ey);
        return q;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid       <= 1'b0;
            req.point_x     <= '0;
            req.point_y     <= '0;
            req.seg_start_x <= '0;
            req.seg_start_y <= '0;
            req.seg_end_x   <= '0;
            req.seg_end_y   <= '0;
        end
        else if (!req.valid || req.ready)
        begin
            if (req.valid)
                nearest_q.push_back(nearest_point({req.point_x, req.point_y,
                    req.seg_start_x, req.seg_start_y, req.seg_end_x, req.seg_end_y}));
            if (query_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                query_t q;
                q = query_q.pop_front();
                req.valid       <= 1'b1;
                req.point_x     <= q.px;
                req.point_y     <= q.py;
                req.seg_start_x <= q.sx;
                req.seg_start_y <= q.sy;
                req.seg_end_x   <= q.ex;
                req.seg_end_y   <= q.ey;
            end
            else
                req.valid <= 1'b0;
        end
    end

    // receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            rsp_count <= rsp_count + 1;
            if (nearest_q.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected rsp transfer: dist_sq=%0d foot=(%0d,%0d) region=%0d",
                        rsp.dist_sq, rsp.foot_x, rsp.foot_y, rsp.region);
            end
            else
            begin
                nearest_t e;
                e = nearest_q.pop_front();
                region_hits[e.region] <= region_hits[e.region] + 1;
                if (rsp.dist_sq !== e.dist_sq || rsp.foot_x !== e.foot_x ||
                    rsp.foot_y !== e.foot_y || rsp.region !== e.region)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: exp %0d (%0d,%0d) r%0d, got %0d (%0d,%0d) r%0d",
                            e.dist_sq, e.foot_x, e.foot_y, e.region,
                            rsp.dist_sq, rsp.foot_x, rsp.foot_y, rsp.region);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == MAX_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic run_phase(int s_idle, int r_idle, int n);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        repeat (n)
            query_q.push_back(rand_query());
        while (query_q.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n         = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        query_q.push_back(mk(3, 4, 3, 4, 3, 4));
        query_q.push_back(mk(32767, 32767, -32768, -32768, -32768, -32768));
        query_q.push_back(mk(-32768, -32768, 32767, 32767, 32767, 32767));
        query_q.push_back(mk(-5, 0, 0, 0, 10, 0));
        query_q.push_back(mk(15, 3, 0, 0, 10, 0));
        query_q.push_back(mk(4, 7, 0, 0, 10, 0));
        query_q.push_back(mk(0, 9, 0, 0, 10, 0));
        query_q.push_back(mk(10, -9, 0, 0, 10, 0));
        query_q.push_back(mk(1, 0, 0, 0, 2, 2));
        query_q.push_back(mk(0, 1, 0, 0, 4, 1));
        query_q.push_back(mk(-32768, 32767, -32768, -32768, 32767, 32767));
        query_q.push_back(mk(32767, -32768, -32768, -32768, 32767, 32767));
        query_q.push_back(mk(32767, 32767, -32768, 32767, 32767, -32768));
        query_q.push_back(mk(-32768, -32768, 32767, -32768, -32768, 32767));
        query_q.push_back(mk(-32768, -32768, 32767, 32767, -32768, 32767));
        query_q.push_back(mk(0, 0, -32768, -32768, -32767, -32768));
        query_q.push_back(mk(-1, -1, 1, 1, 2, 3));
        query_q.push_back(mk(-21845, 10922, 21845, -10923, -12345, 23456));
        query_q.push_back(mk(1, 1, 0, 0, -1, -1));
        query_q.push_back(mk(-3, 2, 0, 0, -1, 3));
        while (query_q.size() > 0)
            @(posedge clk);

        run_phase(21, 82, 650);
        run_phase(82, 21, 650);
        run_phase(0, 0, 650);

        @(posedge clk);
        while (req.valid || nearest_q.size() > 0)
            @(posedge clk);
        repeat (COORD_BITS + 20) @(posedge clk);

        $display("%0d responses checked: zero-length %0d, start %0d, end %0d, interior %0d",
            rsp_count, region_hits[0], region_hits[1], region_hits[2], region_hits[3]);
        $display("three stall profiles run, %0d mismatches", mismatches);
        if (mismatches == 0 && nearest_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
